// ----- hdl/adc_trimmed_mean_slew_filter_macros.svh -----
// Assertion macros for the checker of the trimmed-mean slew filter.
// Depends on a clk and rst in the scope of each use.
`ifndef ADC_TRIMMED_MEAN_SLEW_FILTER_MACROS_SVH
`define ADC_TRIMMED_MEAN_SLEW_FILTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ATMSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ATMSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/atmsf_pkg.sv -----
// Package for the trimmed-mean slew filter: widths, types, register codes, constants.
// No dependencies.
`default_nettype none

package atmsf_pkg;

  localparam int SAMPLE_W = 12;
  localparam int CHAN_W   = 3;
  localparam int LANES    = 5;
  localparam int SUM_W    = 14;
  localparam int Q_W      = 9;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  // floor(x / 30) = (x * DIV30_MUL) >> DIV30_SHIFT for every x below 2**SUM_W
  localparam logic [14:0] DIV30_MUL   = 15'd17477;
  localparam int          DIV30_SHIFT = 19;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef sample_t [LANES-1:0] sample_vec_t;
  typedef logic [CHAN_W-1:0]   chan_t;
  typedef logic [2:0]          rank_t;

  typedef enum logic {
    REG_RISE = 1'b0,
    REG_FALL = 1'b1
  } reg_sel_t;

  localparam sample_t RISE_RESET = 12'd50;
  localparam sample_t FALL_RESET = 12'd60;

  typedef struct packed {
    logic    load;
    chan_t   channel;
    sample_t quant;
  } slew_req_t;

endpackage

`default_nettype wire

// ----- hdl/atmsf_rank_lane.sv -----
// One sorting lane: ranks its own reading against the other four of the request.
// Depends on atmsf_pkg.
`default_nettype none

module atmsf_rank_lane #(
  parameter int LANE = 0
) (
  input  atmsf_pkg::sample_vec_t samples,
  output logic                   keep
);
  import atmsf_pkg::*;

  rank_t   rank;
  sample_t own;

  assign own = samples[LANE];

  // ties break by lane number, so ranks form a permutation
  always_comb begin
    rank = '0;
    for (int j = 0; j < LANES; j++) begin
      if (j != LANE) begin
        if ((samples[j] < own) || ((samples[j] == own) && (j < LANE))) begin
          rank = rank + 3'd1;
        end
      end
    end
  end

  assign keep = (rank != 3'd0) && (rank != 3'(LANES - 1));

endmodule

`default_nettype wire

// ----- hdl/atmsf_merge.sv -----
// Merge stage: sums the readings that the lanes kept (the middle three).
// Depends on atmsf_pkg.
`default_nettype none

module atmsf_merge (
  input  atmsf_pkg::sample_vec_t       samples,
  input  logic [atmsf_pkg::LANES-1:0]  keep,
  output logic [atmsf_pkg::SUM_W-1:0]  sum
);
  import atmsf_pkg::*;

  always_comb begin
    sum = '0;
    for (int i = 0; i < LANES; i++) begin
      if (keep[i]) begin
        sum = sum + SUM_W'(samples[i]);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/atmsf_slew.sv -----
// Per-channel filtered store and slew limiter.
// Depends on atmsf_pkg.
`default_nettype none

module atmsf_slew #(
  parameter int CHANNELS = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  atmsf_pkg::slew_req_t req,
  input  atmsf_pkg::sample_t  rise_limit,
  input  atmsf_pkg::sample_t  fall_limit,
  output atmsf_pkg::sample_t  filt
);
  import atmsf_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  sample_t          store [CHANNELS];
  logic [IDX_W-1:0] idx;
  logic             in_range;
  sample_t          old;
  sample_t          diff_up;
  sample_t          diff_dn;
  logic [12:0]      up_sum;

  assign idx      = IDX_W'(req.channel);
  assign in_range = int'(req.channel) < CHANNELS;
  assign old      = in_range ? store[idx] : '0;
  assign diff_up  = req.quant - old;
  assign diff_dn  = old - req.quant;
  assign up_sum   = {1'b0, old} + {1'b0, rise_limit};

  always_comb begin
    if (!in_range) begin
      filt = '0;
    end else if (req.quant >= old) begin
      filt = (diff_up > rise_limit) ? up_sum[11:0] : req.quant;
    end else begin
      filt = (diff_dn > fall_limit) ? (old - fall_limit) : req.quant;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CHANNELS; k++) begin
        store[k] <= '0;
      end
    end else if (req.load && in_range) begin
      store[idx] <= filt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/adc_trimmed_mean_slew_filter.sv -----
// Trimmed-mean ADC filter with per-channel slew limit. One request carries five
// readings of one channel; five ranking lanes keep the middle three, the merge stage
// sums them, a reciprocal multiply divides by 30, and the last stage quantizes to a
// multiple of ten, moves the channel's stored value toward it by at most rise_limit
// up or fall_limit down, stores it and presents the result. One request per cycle
// is accepted while in_stall is low. The rate is set by the last stage, which reads
// the channel store and writes it back in the same cycle. Stored values reset to
// zero; limits reset to 50 and 60 and are written over the APB port at byte
// addresses 0 and 4. Channels at or above CHANNELS return a filtered value of zero
// and change no stored value.
// Depends on atmsf_pkg, atmsf_rank_lane, atmsf_merge, atmsf_slew.
`default_nettype none

module adc_trimmed_mean_slew_filter #(
  parameter int CHANNELS = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [atmsf_pkg::ADDR_W-1:0]      paddr,
  input  logic [atmsf_pkg::DATA_W-1:0]      pwdata,
  output logic [atmsf_pkg::DATA_W-1:0]      prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  atmsf_pkg::chan_t                  channel,
  input  atmsf_pkg::sample_t                sample_a,
  input  atmsf_pkg::sample_t                sample_b,
  input  atmsf_pkg::sample_t                sample_c,
  input  atmsf_pkg::sample_t                sample_d,
  input  atmsf_pkg::sample_t                sample_e,
  output logic                              out_valid,
  input  logic                              out_stall,
  output atmsf_pkg::chan_t                  channel_out,
  output atmsf_pkg::sample_t                quantized_value,
  output atmsf_pkg::sample_t                filtered_value
);
  import atmsf_pkg::*;

  sample_t rise_limit;
  sample_t fall_limit;
  logic    cfg_write;

  sample_vec_t      samples_in;
  logic [LANES-1:0] keep_in;

  logic             v1;
  chan_t            ch1;
  sample_vec_t      samp1;
  logic [LANES-1:0] keep1;
  logic [SUM_W-1:0] sum_merge;

  logic             v2;
  chan_t            ch2;
  logic [SUM_W-1:0] sum2;
  logic [28:0]      prod;

  logic             v3;
  chan_t            ch3;
  logic [Q_W-1:0]   q3;
  sample_t          quant;

  logic en1, en2, en3, en4;
  slew_req_t slew_req;
  sample_t   filt;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_limit <= RISE_RESET;
      fall_limit <= FALL_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel_t'(paddr[2]))
        REG_RISE: rise_limit <= pwdata[SAMPLE_W-1:0];
        REG_FALL: fall_limit <= pwdata[SAMPLE_W-1:0];
        default:  rise_limit <= rise_limit;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel_t'(paddr[2]))
      REG_RISE: prdata = DATA_W'(rise_limit);
      REG_FALL: prdata = DATA_W'(fall_limit);
      default:  prdata = '0;
    endcase
  end

  // stage enables: advance when empty or when the next stage advances
  assign en4      = !out_valid || !out_stall;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  assign samples_in = {sample_e, sample_d, sample_c, sample_b, sample_a};

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    atmsf_rank_lane #(
      .LANE(i)
    ) u_lane (
      .samples(samples_in),
      .keep   (keep_in[i])
    );
  end

  atmsf_merge u_merge (
    .samples(samp1),
    .keep   (keep1),
    .sum    (sum_merge)
  );

  assign prod  = {15'b0, sum2} * {14'b0, DIV30_MUL};
  assign quant = {q3, 3'b000} + SAMPLE_W'({q3, 1'b0});

  assign slew_req.load    = v3 && en4;
  assign slew_req.channel = ch3;
  assign slew_req.quant   = quant;

  atmsf_slew #(
    .CHANNELS(CHANNELS)
  ) u_slew (
    .clk       (clk),
    .rst       (rst),
    .req       (slew_req),
    .rise_limit(rise_limit),
    .fall_limit(fall_limit),
    .filt      (filt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en4) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ch1   <= channel;
      samp1 <= samples_in;
      keep1 <= keep_in;
    end
    if (en2) begin
      ch2  <= ch1;
      sum2 <= sum_merge;
    end
    if (en3) begin
      ch3 <= ch2;
      q3  <= prod[DIV30_SHIFT +: Q_W];
    end
    if (en4 && v3) begin
      channel_out     <= ch3;
      quantized_value <= quant;
      filtered_value  <= filt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/atmsf_checker.sv -----
// Port-level checker for the trimmed-mean slew filter, bound to the top level.
// Depends on atmsf_pkg and adc_trimmed_mean_slew_filter_macros.svh.
`default_nettype none
`include "adc_trimmed_mean_slew_filter_macros.svh"

module atmsf_checker #(
  parameter int CHANNELS = 5
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input atmsf_pkg::chan_t    channel_out,
  input atmsf_pkg::sample_t  quantized_value,
  input atmsf_pkg::sample_t  filtered_value
);
  import atmsf_pkg::*;

  logic out_held;
  logic bad_channel;

  assign out_held    = out_valid && out_stall;
  assign bad_channel = out_valid && (int'(channel_out) >= CHANNELS);

  `ATMSF_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(channel_out) && $stable(quantized_value) && $stable(filtered_value), "stalled result changed")
  `ATMSF_ASSERT_NOW(a_flow, !out_stall, !in_stall, "input stalled while output flows")
  `ATMSF_ASSERT_NOW(a_reset_empty, $past(rst), !out_valid, "result present after reset")
  `ATMSF_ASSERT_NOW(a_bad_channel, bad_channel, filtered_value == '0, "unknown channel gave a value")
  `ATMSF_ASSERT_NOW(a_quant_range, out_valid || in_valid, !out_valid || (quantized_value <= 12'd4090), "quantized value out of range")

endmodule

bind adc_trimmed_mean_slew_filter atmsf_checker #(
  .CHANNELS(CHANNELS)
) u_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .channel_out    (channel_out),
  .quantized_value(quantized_value),
  .filtered_value (filtered_value)
);

`default_nettype wire

// ----- dv/filter_result_monitor.sv -----
`timescale 1ns / 1ps
// Result monitor for the trimmed-mean slew filter: mirrors the limit registers from
// APB writes, predicts each result from the accepted request and compares in order.
// Depends on atmsf_pkg.
module filter_result_monitor #(
  parameter int CHANNELS = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [atmsf_pkg::ADDR_W-1:0]        paddr,
  input  logic [atmsf_pkg::DATA_W-1:0]        pwdata,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  atmsf_pkg::chan_t                    channel,
  input  atmsf_pkg::sample_t                  sample_a,
  input  atmsf_pkg::sample_t                  sample_b,
  input  atmsf_pkg::sample_t                  sample_c,
  input  atmsf_pkg::sample_t                  sample_d,
  input  atmsf_pkg::sample_t                  sample_e,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  atmsf_pkg::chan_t                    channel_out,
  input  atmsf_pkg::sample_t                  quantized_value,
  input  atmsf_pkg::sample_t                  filtered_value,
  output int                                  results_outstanding,
  output int                                  mismatches
);
  import atmsf_pkg::*;

  typedef struct packed {
    chan_t   channel;
    sample_t quant;
    sample_t filtered;
  } filter_result_t;

  sample_t        filtered_mirror [CHANNELS];
  sample_t        rise_cap;
  sample_t        fall_cap;
  filter_result_t pending_filter_results [$];
  int             fail_total;

  function automatic filter_result_t predict_filter(input chan_t ch, input sample_vec_t raw);
    sample_t        v [LANES];
    sample_t        swap;
    logic [SUM_W-1:0] middle_sum;
    sample_t        mean;
    sample_t        old;
    filter_result_t r;
    int             i;
    int             j;
    for (i = 0; i < LANES; i++) v[i] = raw[i];
    for (i = 0; i < LANES - 1; i++) begin
      for (j = 0; j < LANES - 1 - i; j++) begin
        if (v[j] > v[j+1]) begin
          swap = v[j];
          v[j] = v[j+1];
          v[j+1] = swap;
        end
      end
    end
    middle_sum = SUM_W'(v[1]) + SUM_W'(v[2]) + SUM_W'(v[3]);
    mean = sample_t'(middle_sum / 3);
    r.channel = ch;
    r.quant = sample_t'((mean / 10) * 10);
    r.filtered = '0;
    if (int'(ch) < CHANNELS) begin
      old = filtered_mirror[ch];
      if (r.quant >= old) begin
        r.filtered = (r.quant - old > rise_cap) ? sample_t'(old + rise_cap) : r.quant;
      end else begin
        r.filtered = (old - r.quant > fall_cap) ? sample_t'(old - fall_cap) : r.quant;
      end
      filtered_mirror[ch] = r.filtered;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    filter_result_t want;
    filter_result_t got;
    if (rst) begin
      foreach (filtered_mirror[i]) filtered_mirror[i] = '0;
      rise_cap = RISE_RESET;
      fall_cap = FALL_RESET;
      pending_filter_results.delete();
      fail_total = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        case (reg_sel_t'(paddr[ADDR_W-1:2]))
          REG_RISE: rise_cap = pwdata[SAMPLE_W-1:0];
          REG_FALL: fall_cap = pwdata[SAMPLE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{channel: channel_out, quant: quantized_value, filtered: filtered_value};
        if (pending_filter_results.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("%0t: unpredicted result chan %0d quant %0d filt %0d",
                     $realtime, got.channel, got.quant, got.filtered);
        end else begin
          want = pending_filter_results.pop_front();
          if (got.channel !== want.channel || got.quant !== want.quant ||
              got.filtered !== want.filtered) begin
            fail_total++;
            if (fail_total <= 10)
              $display("%0t: mismatch expected chan %0d quant %0d filt %0d, got chan %0d quant %0d filt %0d",
                       $realtime, want.channel, want.quant, want.filtered,
                       got.channel, got.quant, got.filtered);
          end
        end
      end
      if (in_valid && !in_stall)
        pending_filter_results.push_back(predict_filter(channel,
          {sample_e, sample_d, sample_c, sample_b, sample_a}));
    end
    results_outstanding <= pending_filter_results.size();
    mismatches <= fail_total;
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Top of the trimmed-mean slew filter testbench: clock, reset, APB limit writes,
// request and result-side stall generation, watchdog and verdict.
// Depends on atmsf_pkg, adc_trimmed_mean_slew_filter and filter_result_monitor.
module testbench;
  import atmsf_pkg::*;

  localparam int CHANNELS     = 5;
  localparam int PHASE_ITEMS  = 225;
  localparam int HOLD_CYCLES  = 80;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 12;

  logic              clk;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  chan_t             channel = '0;
  sample_t           sample_a = '0;
  sample_t           sample_b = '0;
  sample_t           sample_c = '0;
  sample_t           sample_d = '0;
  sample_t           sample_e = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  chan_t             channel_out;
  sample_t           quantized_value;
  sample_t           filtered_value;
  int                results_outstanding;
  int                mismatches;

  int send_gap_pct = 28;
  int recv_stall_pct = 77;
  int hold_ticket = 0;
  int quiet_cycles = 0;
  int drift_center [8];

  adc_trimmed_mean_slew_filter #(.CHANNELS(CHANNELS)) u_top (.*);

  filter_result_monitor #(.CHANNELS(CHANNELS)) u_monitor (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : result_side
    int hold_served;
    hold_served = 0;
    forever begin
      if (hold_ticket != hold_served) begin
        hold_served++;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic sample_vec_t five_readings(input sample_t a, input sample_t b,
                                                input sample_t c, input sample_t d,
                                                input sample_t e);
    return {e, d, c, b, a};
  endfunction

  function automatic sample_vec_t draw_readings(input int center);
    sample_vec_t r;
    int          style;
    int          x;
    style = $urandom_range(9);
    for (int k = 0; k < LANES; k++) begin
      if (style < 4) begin
        r[k] = sample_t'($urandom_range(4095));
      end else if (style < 8) begin
        x = center + int'($urandom_range(48)) - 24;
        r[k] = sample_t'(x < 0 ? 0 : (x > 4095 ? 4095 : x));
        if ($urandom_range(4) == 0) r[k] = sample_t'($urandom_range(4095));
      end else begin
        r[k] = $urandom_range(1) ? '1 : '0;
      end
    end
    return r;
  endfunction

  task automatic write_limit(input reg_sel_t sel, input sample_t value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({sel, 2'b00});
    pwdata <= {(DATA_W-SAMPLE_W)'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic offer_readings(input chan_t ch, input sample_vec_t r);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    channel <= ch;
    sample_a <= r[0];
    sample_b <= r[1];
    sample_c <= r[2];
    sample_d <= r[3];
    sample_e <= r[4];
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    chan_t   ch;
    int      step;
    sample_t rise_val;
    sample_t fall_val;
    foreach (drift_center[i]) drift_center[i] = 2048;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // exact-limit rise and fall, capped steps, trimming, truncation, bad channels
    offer_readings(3'd0, five_readings(0, 0, 0, 0, 0));
    offer_readings(3'd0, five_readings(4095, 4095, 4095, 4095, 4095));
    offer_readings(3'd0, five_readings(4095, 4095, 4095, 4095, 4095));
    offer_readings(3'd0, five_readings(4095, 4095, 4095, 4095, 4095));
    offer_readings(3'd0, five_readings(0, 0, 0, 0, 0));
    offer_readings(3'd1, five_readings(50, 50, 50, 50, 50));
    offer_readings(3'd1, five_readings(4095, 0, 100, 100, 100));
    offer_readings(3'd1, five_readings(40, 40, 40, 40, 40));
    offer_readings(3'd3, five_readings(1, 1, 2, 0, 4095));
    offer_readings(3'd3, five_readings(19, 29, 19, 4095, 0));
    offer_readings(3'd3, five_readings(29, 29, 29, 29, 29));
    offer_readings(3'd4, five_readings(4095, 4095, 4095, 0, 0));
    offer_readings(3'd4, five_readings(4094, 4093, 4092, 4091, 4095));
    offer_readings(3'd4, five_readings(12'hAAA, 12'h555, 12'hFFF, 12'h000, 12'hAAA));
    offer_readings(3'd2, five_readings(500, 400, 300, 200, 100));
    offer_readings(3'd5, five_readings(4095, 4095, 4095, 4095, 4095));
    offer_readings(3'd6, five_readings(12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA));
    offer_readings(3'd7, five_readings(12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555));
    offer_readings(3'd1, five_readings(0, 0, 0, 0, 0));

    for (int ph = 0; ph < 6; ph++) begin
      settle_results();
      case (ph)
        0: begin rise_val = 12'd4095; fall_val = 12'd4095; end
        1: begin rise_val = 12'd0;    fall_val = 12'd0;    end
        2: begin rise_val = 12'd4095; fall_val = 12'd0;    end
        3: begin
          rise_val = sample_t'($urandom_range(80));
          fall_val = sample_t'($urandom_range(80));
        end
        4: begin
          rise_val = sample_t'($urandom_range(4095));
          fall_val = sample_t'($urandom_range(4095));
        end
        default: begin rise_val = 12'd1; fall_val = sample_t'($urandom_range(80)); end
      endcase
      write_limit(REG_RISE, rise_val);
      write_limit(REG_FALL, fall_val);
      if (ph < 2) begin
        send_gap_pct = 28;
        recv_stall_pct = 77;
      end else if (ph < 4) begin
        send_gap_pct = 77;
        recv_stall_pct = 28;
      end else begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      // hold the result side long enough for the pipeline to back up
      if (ph == 4) hold_ticket++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        ch = ($urandom_range(9) == 0) ? chan_t'($urandom_range(7, 5))
                                      : chan_t'($urandom_range(4));
        step = int'($urandom_range(300)) - 150;
        drift_center[ch] = drift_center[ch] + step;
        if ($urandom_range(19) == 0) drift_center[ch] = int'($urandom_range(4095));
        if (drift_center[ch] < 0) drift_center[ch] = 0;
        if (drift_center[ch] > 4095) drift_center[ch] = 4095;
        offer_readings(ch, draw_readings(drift_center[ch]));
      end
    end

    settle_results();
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
